// ===== src/xflp_pkg.sv =====
// Shared types, constants and helpers for the letter-parity Fenwick tree block.
package xflp_pkg;

  localparam int unsigned LETTER_COUNT = 26;
  localparam int unsigned CODE_W       = 5;
  localparam int unsigned IDX_W        = 12;
  localparam logic [CODE_W-1:0] EMPTY_CODE = 5'd31;

  typedef logic [LETTER_COUNT-1:0] mask_t;
  typedef logic [CODE_W-1:0]       code_t;
  typedef logic [IDX_W-1:0]        idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_U_LTR,
    ST_U_RD,
    ST_U_WR,
    ST_Q1_ACC,
    ST_Q1_WAIT,
    ST_Q2_ACC,
    ST_Q2_WAIT,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // latch the accepted word
    logic clr_we;     // write reset values at the clear counter
    logic let_we;     // write the new letter, latch the delta
    logic tree_we;    // write back node ^ delta
    logic node_up;    // step to the next node of the update path
    logic node_down;  // step to the next node of the prefix walk
    logic node_left;  // start the walk ending at left - 1
    logic acc_ld;     // fold the read node into the accumulator
    logic out_ld;     // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_query;
    logic pos_ok;
    logic range_bad;
    logic clr_last;
    logic up_done;
    logic down_end;
    logic left_zero;
    logic out_free;
  } dp_sts_t;

  // One-hot letter bit; codes past z count as empty
  function automatic mask_t letter_bit(input code_t code);
    mask_t m;
    m = '0;
    if (code < CODE_W'(LETTER_COUNT)) begin
      m[code] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== src/xflp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module xflp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/xflp_ctrl.sv =====
// Controller state machine: clearing sweep, update walk and two prefix walks.
module xflp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  xflp_pkg::dp_sts_t sts,
  output xflp_pkg::dp_cmd_t cmd
);
  import xflp_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (!sts.is_query) begin
          state_nxt = sts.pos_ok ? ST_U_LTR : ST_IDLE;
        end else begin
          state_nxt = sts.range_bad ? ST_FIN : ST_Q1_ACC;
        end
      end
      ST_U_LTR:   state_nxt = ST_U_WR;
      ST_U_RD:    state_nxt = ST_U_WR;
      ST_U_WR: begin
        state_nxt = sts.up_done ? ST_IDLE : ST_U_RD;
      end
      ST_Q1_ACC: begin
        if (!sts.down_end) begin
          state_nxt = ST_Q1_WAIT;
        end else begin
          state_nxt = sts.left_zero ? ST_FIN : ST_Q2_WAIT;
        end
      end
      ST_Q1_WAIT: state_nxt = ST_Q1_ACC;
      ST_Q2_ACC: begin
        state_nxt = sts.down_end ? ST_FIN : ST_Q2_WAIT;
      end
      ST_Q2_WAIT: state_nxt = ST_Q2_ACC;
      ST_FIN: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_we = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_U_LTR: cmd.let_we = 1'b1;
      ST_U_WR: begin
        cmd.tree_we = 1'b1;
        cmd.node_up = 1'b1;
      end
      ST_Q1_ACC: begin
        cmd.acc_ld    = 1'b1;
        cmd.node_down = !sts.down_end;
        cmd.node_left = sts.down_end;
      end
      ST_Q2_ACC: begin
        cmd.acc_ld    = 1'b1;
        cmd.node_down = !sts.down_end;
      end
      ST_FIN: cmd.out_ld = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/xflp_dp.sv =====
// Datapath: item registers, node walker, both stores, accumulator and output register.
module xflp_dp #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  xflp_pkg::dp_cmd_t     cmd,
  output xflp_pkg::dp_sts_t     sts,
  input  logic                  in_action,
  input  xflp_pkg::idx_t        in_position,
  input  xflp_pkg::code_t       in_letter,
  input  xflp_pkg::idx_t        in_left,
  input  xflp_pkg::idx_t        in_right,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_is_palindrome_anagram,
  output xflp_pkg::mask_t       out_odd_letter_mask,
  output logic                  out_range_error
);
  import xflp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LENGTH);
  // Node width: one bit above the address or index, top bit marks "before zero"
  localparam int unsigned NW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam logic [NW-1:0] MAX_N  = NW'(MAX_LENGTH);
  localparam logic [NW-1:0] LAST_N = NW'(MAX_LENGTH - 1);
  localparam logic [AW-1:0] LAST_A = AW'(MAX_LENGTH - 1);

  logic            action_r;
  idx_t            pos_r, left_r, right_r;
  code_t           letter_r;
  logic [NW-1:0]   node_r, node_nxt;
  logic [AW-1:0]   clr_cnt_r;
  mask_t           delta_r, acc_r;
  logic            out_valid_r, out_ok_r, out_err_r;
  mask_t           out_mask_r;

  logic [NW-1:0]   pos_n, left_n, right_n, right_clamp, left_m1, left_clamp;
  logic [NW-1:0]   up_n, down_n;
  mask_t           tree_rdata, tree_wdata;
  code_t           let_rdata, let_wdata;
  logic [AW-1:0]   tree_waddr, let_waddr;
  logic            range_bad, odd_len, ok;

  // Widen indices to node width
  assign pos_n   = NW'(pos_r);
  assign left_n  = NW'(left_r);
  assign right_n = NW'(in_right);

  // Clamp the walk starts to the last stored position
  assign right_clamp = (right_n >= MAX_N) ? LAST_N : right_n;
  assign left_m1     = left_n - NW'(1);
  assign left_clamp  = (!left_m1[NW-1] && (left_m1 >= MAX_N)) ? LAST_N : left_m1;

  // Fenwick steps
  assign up_n   = node_r | (node_r + NW'(1));
  assign down_n = (node_r & (node_r + NW'(1))) - NW'(1);

  assign range_bad = left_r > right_r;
  assign odd_len   = left_r[0] == right_r[0];

  // Status to the controller
  always_comb begin
    sts           = '0;
    sts.is_query  = action_r;
    sts.pos_ok    = pos_n < MAX_N;
    sts.range_bad = range_bad;
    sts.clr_last  = clr_cnt_r == LAST_A;
    sts.up_done   = up_n >= MAX_N;
    sts.down_end  = down_n[NW-1];
    sts.left_zero = left_r == '0;
    sts.out_free  = !out_valid_r || out_tready;
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      pos_r    <= in_position;
      letter_r <= in_letter;
      left_r   <= in_left;
      right_r  <= in_right;
    end
  end

  // Walk the node index
  always_comb begin
    node_nxt = node_r;
    if (cmd.load) begin
      node_nxt = in_action ? right_clamp : NW'(in_position);
    end else if (cmd.node_up) begin
      node_nxt = up_n;
    end else if (cmd.node_down) begin
      node_nxt = down_n;
    end else if (cmd.node_left) begin
      node_nxt = left_clamp;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
  end

  // Advance the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Latch the letter change and fold nodes into the accumulator
  always_ff @(posedge clk) begin
    if (cmd.let_we) begin
      delta_r <= letter_bit(let_rdata) ^ letter_bit(letter_r);
    end
    if (cmd.load) begin
      acc_r <= '0;
    end else if (cmd.acc_ld) begin
      acc_r <= acc_r ^ tree_rdata;
    end
  end

  // Store write ports
  assign tree_waddr = cmd.clr_we ? clr_cnt_r : node_r[AW-1:0];
  assign tree_wdata = cmd.clr_we ? '0 : (tree_rdata ^ delta_r);
  assign let_waddr  = cmd.clr_we ? clr_cnt_r : pos_n[AW-1:0];
  assign let_wdata  = cmd.clr_we ? EMPTY_CODE : letter_r;

  xflp_ram #(
    .WIDTH (LETTER_COUNT),
    .DEPTH (MAX_LENGTH)
  ) u_tree (
    .clk   (clk),
    .we    (cmd.clr_we || cmd.tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (node_r[AW-1:0]),
    .rdata (tree_rdata)
  );

  xflp_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_LENGTH)
  ) u_letters (
    .clk   (clk),
    .we    (cmd.clr_we || cmd.let_we),
    .waddr (let_waddr),
    .wdata (let_wdata),
    .raddr (pos_n[AW-1:0]),
    .rdata (let_rdata)
  );

  // Palindrome test: even length needs no odd letter, odd length at most one
  assign ok = !range_bad &&
              (odd_len ? ((acc_r & (acc_r - mask_t'(1))) == '0) : (acc_r == '0));

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_ok_r   <= ok;
      out_mask_r <= range_bad ? '0 : acc_r;
      out_err_r  <= range_bad;
    end
  end

  assign out_tvalid                = out_valid_r;
  assign out_is_palindrome_anagram = out_ok_r;
  assign out_odd_letter_mask       = out_mask_r;
  assign out_range_error           = out_err_r;

endmodule

// ===== src/xor_fenwick_letter_parity.sv =====
// Top level of the letter-parity Fenwick tree with palindrome-anagram queries.
//
//  channel | dir | ports                     | word
//  --------+-----+---------------------------+-----------------------------------------
//  in      | in  | in_tvalid/tready/tdata/tuser | set letter or query range
//  out     | out | out_tvalid/tready/tdata/tuser| query result, one per query
//
// A set walks the update path (up to log2(MAX_LENGTH) + 1 tree nodes), each node a
// read-modify-write on the tree RAM port. A query walks the prefix path ending at
// right and, unless left is zero, the one ending at left - 1 (up to 2 * log2(MAX_LENGTH)
// nodes in all); a reversed range skips both walks. After reset a clearing pass writes
// every entry of both stores; in_tready stays low meanwhile. A result waits in the
// output register while the next word is taken; a query stalls at its end only while
// the previous result is unread.
module xor_fenwick_letter_parity #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // position[11:0], letter[16:12], left[28:17], right[40:29]
  input  logic        in_tuser,   // action: 0 set, 1 query
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // is_palindrome_anagram[0], odd_letter_mask[26:1]
  output logic        out_tuser   // range_error
);
  import xflp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    ok;
  mask_t   mask;

  xflp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  xflp_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .sts                       (sts),
    .in_action                 (in_tuser),
    .in_position               (in_tdata[11:0]),
    .in_letter                 (in_tdata[16:12]),
    .in_left                   (in_tdata[28:17]),
    .in_right                  (in_tdata[40:29]),
    .out_tvalid                (out_tvalid),
    .out_tready                (out_tready),
    .out_is_palindrome_anagram (ok),
    .out_odd_letter_mask       (mask),
    .out_range_error           (out_tuser)
  );

  // Pack the result word
  assign out_tdata = {5'd0, mask, ok};

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the letter-parity Fenwick tree with palindrome-anagram queries.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xflp_pkg::*;

  localparam int unsigned STRING_LEN   = 4096;
  localparam int unsigned RANDOM_WORDS = 530;
  localparam int unsigned IDLE_MAX     = 13;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned STALL_LIMIT  = 20000;

  typedef enum logic {
    ACT_SET   = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef struct packed {
    action_t act;
    idx_t    pos;
    code_t   ltr;
    idx_t    lo;
    idx_t    hi;
  } word_t;

  typedef struct packed {
    logic  palin;
    mask_t odd_mask;
    logic  rev;
  } answer_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  // Mirror of the string held by the block, one letter code per position
  code_t       text_codes [STRING_LEN];
  answer_t     pending_answers [$];
  int unsigned fail_count   = 0;
  int unsigned word_count;
  int unsigned stall_cycles = 0;
  bit          in_idle_en;
  bit          out_idle_en;

  xor_fenwick_letter_parity #(
    .MAX_LENGTH(STRING_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned draw_gap(input bit idle_en);
    return idle_en ? $urandom_range(0, IDLE_MAX) : 0;
  endfunction

  // Build a set word; the query fields carry noise
  function automatic word_t set_word(input int unsigned pos, input int unsigned ltr);
    word_t w;
    w.act = ACT_SET;
    w.pos = idx_t'(pos);
    w.ltr = code_t'(ltr);
    w.lo  = idx_t'($urandom);
    w.hi  = idx_t'($urandom);
    return w;
  endfunction

  // Build a query word; the set fields carry noise
  function automatic word_t query_word(input int unsigned lo, input int unsigned hi);
    word_t w;
    w.act = ACT_QUERY;
    w.pos = idx_t'($urandom);
    w.ltr = code_t'($urandom);
    w.lo  = idx_t'(lo);
    w.hi  = idx_t'(hi);
    return w;
  endfunction

  // XOR the letter bits over lo..hi and apply the palindrome rule
  function automatic answer_t range_answer(input idx_t lo, input idx_t hi);
    answer_t     a;
    mask_t       m;
    int unsigned span;
    a = '0;
    m = '0;
    if (lo > hi) begin
      a.rev = 1'b1;
      return a;
    end
    for (int i = lo; i <= hi; i++) begin
      if (text_codes[i] < LETTER_COUNT) begin
        m[text_codes[i]] = ~m[text_codes[i]];
      end
    end
    span       = hi - lo + 1;
    a.odd_mask = m;
    if (span % 2 == 0) begin
      a.palin = (m == '0);
    end else begin
      a.palin = ((m & (m - 1'b1)) == '0);
    end
    return a;
  endfunction

  // Update the string mirror or queue the expected answer for one accepted word
  function automatic void apply_word(input word_t w);
    if (w.act == ACT_SET) begin
      text_codes[w.pos] = w.ltr;
    end else begin
      pending_answers.push_back(range_answer(w.lo, w.hi));
    end
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input word_t w);
    int unsigned gap;
    gap = draw_gap(in_idle_en);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.act;
    in_tdata  <= {7'b0, w.hi, w.lo, w.ltr, w.pos};
    do @(posedge clk); while (!in_tready);
    apply_word(w);
    word_count++;
  endtask

  // Queries on the empty string, including the full range and single positions at both ends
  task automatic test_empty_string();
    in_idle_en = 1'b0;
    send_word(query_word(0, 0));
    send_word(query_word(0, 1));
    send_word(query_word(0, STRING_LEN - 1));
    send_word(query_word(STRING_LEN - 1, STRING_LEN - 1));
  endtask

  // First and last letter at the first and last position
  task automatic test_letter_extremes();
    in_idle_en = 1'b1;
    send_word(set_word(0, 0));
    send_word(set_word(STRING_LEN - 1, 25));
    send_word(set_word(1, 25));
    send_word(query_word(0, 1));
    send_word(query_word(0, STRING_LEN - 1));
    send_word(query_word(STRING_LEN - 1, STRING_LEN - 1));
  endtask

  // Codes past z count as empty and erase what was there
  task automatic test_empty_codes();
    send_word(set_word(2, 26));
    send_word(set_word(0, 31));
    send_word(set_word(STRING_LEN - 1, 30));
    send_word(query_word(0, STRING_LEN - 1));
  endtask

  // Odd length with one odd letter passes, even length with two fails
  task automatic test_palindrome_rule();
    send_word(set_word(10, 0));
    send_word(set_word(11, 1));
    send_word(set_word(12, 0));
    send_word(query_word(10, 12));
    send_word(query_word(10, 11));
  endtask

  // Reversed ranges flag an error with zero mask
  task automatic test_reversed_range();
    in_idle_en = 1'b0;
    send_word(query_word(13, 12));
    send_word(query_word(STRING_LEN - 1, 0));
  endtask

  // Random phases over small windows: mirrored strings, mixed traffic and noise
  task automatic test_random_traffic();
    int unsigned target, base, span, alpha, plen, n, r, lo, hi, ltr;
    target = word_count + RANDOM_WORDS;
    while (word_count < target) begin
      in_idle_en = ($urandom_range(0, 3) != 0);
      span       = $urandom_range(2, 48);
      base       = $urandom_range(0, STRING_LEN - span);
      alpha      = $urandom_range(1, 26);
      if ($urandom_range(0, 9) < 3) begin
        // write a mirrored string, query it, then maybe spoil one letter
        plen = $urandom_range(1, span);
        for (int i = 0; i < (plen + 1) / 2; i++) begin
          ltr = $urandom_range(0, alpha - 1);
          send_word(set_word(base + i, ltr));
          send_word(set_word(base + plen - 1 - i, ltr));
        end
        send_word(query_word(base, base + plen - 1));
        lo = $urandom_range(base, base + plen - 1);
        send_word(query_word(lo, $urandom_range(lo, base + plen - 1)));
        if ($urandom_range(0, 2) == 0) begin
          send_word(set_word($urandom_range(base, base + plen - 1), $urandom_range(0, 31)));
          send_word(query_word(base, base + plen - 1));
        end
      end else begin
        n = $urandom_range(10, 30);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 50) begin
            ltr = ($urandom_range(0, 11) == 0) ? $urandom_range(26, 31)
                                                : $urandom_range(0, alpha - 1);
            send_word(set_word($urandom_range(base, base + span - 1), ltr));
          end else if (r < 85) begin
            lo = $urandom_range(base, base + span - 1);
            send_word(query_word(lo, $urandom_range(lo, base + span - 1)));
          end else if (r < 90) begin
            hi = $urandom_range(base, base + span - 2);
            send_word(query_word($urandom_range(hi + 1, base + span - 1), hi));
          end else if (r < 95) begin
            send_word(query_word($urandom_range(0, STRING_LEN - 1),
                                 $urandom_range(0, STRING_LEN - 1)));
          end else begin
            send_word(set_word($urandom_range(0, STRING_LEN - 1), $urandom_range(0, 31)));
          end
        end
      end
    end
  endtask

  // Drive result ready with random stalls, toggling stretches without stalls
  initial begin
    int unsigned gap;
    out_idle_en = 1'b1;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(out_idle_en);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if ($urandom_range(0, 15) == 0) begin
        out_idle_en = ~out_idle_en;
      end
    end
  end

  // Compare each taken result word with the oldest expected answer
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        $error("result word with no query pending: tdata %h tuser %b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_tdata[0] !== want.palin) begin
          $error("is_palindrome_anagram: expected %b actual %b", want.palin, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[26:1] !== want.odd_mask) begin
          $error("odd_letter_mask: expected %h actual %h", want.odd_mask, out_tdata[26:1]);
          fail_count++;
        end
        if (out_tuser !== want.rev) begin
          $error("range_error: expected %b actual %b", want.rev, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Abort when no word moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    word_count   = 0;
    in_idle_en   = 1'b0;
    foreach (text_codes[i]) text_codes[i] = EMPTY_CODE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_string();
    test_letter_extremes();
    test_empty_codes();
    test_palindrome_rule();
    test_reversed_range();
    test_random_traffic();

    // Drop valid, wait for every answer, then let stray words show up
    in_tvalid <= 1'b0;
    while (pending_answers.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
